FILE: src/irts_pkg.sv
package irts_pkg;

    localparam int MAX_CHANNELS = 4;
    localparam int MAX_FRAMES   = 65536;

    // Channel lanes are fixed by the frame format; the frame index is 16 bits.
    localparam int NUM_LANES  = 4;
    localparam int SAMPLE_W   = 24;
    localparam int THRESH_W   = 23;
    localparam int INDEX_W    = 16;
    localparam int COUNT_W    = INDEX_W + 1;
    localparam int CAP_FRAMES = (MAX_FRAMES > 65536) ? 65536 : MAX_FRAMES;
    localparam int CH_LIMIT   = (MAX_CHANNELS < NUM_LANES) ? MAX_CHANNELS : NUM_LANES;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = THRESH_W;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef t_sample [NUM_LANES-1:0] t_lanes;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INPUT_CHANNELS  = 3'd0,
        REG_LEFT_SOURCE     = 3'd1,
        REG_RIGHT_SOURCE    = 3'd2,
        REG_LEFT_INVERT     = 3'd3,
        REG_RIGHT_INVERT    = 3'd4,
        REG_START_THRESHOLD = 3'd5,
        REG_END_THRESHOLD   = 3'd6,
        REG_TRIM_ENABLE     = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0]          input_channels;
        logic [1:0]          left_source;
        logic [1:0]          right_source;
        logic                left_invert;
        logic                right_invert;
        logic [THRESH_W-1:0] start_threshold;
        logic [THRESH_W-1:0] end_threshold;
        logic [1:0]          trim_enable;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        input_channels:  3'd2,
        left_source:     2'd0,
        right_source:    2'd1,
        left_invert:     1'b0,
        right_invert:    1'b0,
        start_threshold: 23'd839,
        end_threshold:   23'd84,
        trim_enable:     2'd3
    };

    // Flags from the routing stage to the trim scan.
    typedef struct packed {
        logic       hit_start;
        logic       hit_end;
        logic [2:0] channel_count;
    } t_route_flags;

    typedef struct packed {
        t_lanes samples;
        logic   frame_last;
    } t_in_item;

    typedef struct packed {
        t_lanes             samples;
        logic [2:0]         channel_count;
        logic [INDEX_W-1:0] frame_number;
        logic               result_last;
        logic [INDEX_W-1:0] trim_first;
        logic [COUNT_W-1:0] trim_end;
        logic               overflow;
    } t_out_item;

endpackage

FILE: src/irts_intf.sv
interface irts_in_if;
    import irts_pkg::*;
    logic         valid;
    logic         ready;
    logic [23:0]  sample_a;
    logic [23:0]  sample_b;
    logic [23:0]  sample_c;
    logic [23:0]  sample_d;
    logic         frame_last;

    modport source (output valid, sample_a, sample_b, sample_c, sample_d, frame_last,
                    input ready);
    modport sink   (input valid, sample_a, sample_b, sample_c, sample_d, frame_last,
                    output ready);
endinterface

interface irts_out_if;
    import irts_pkg::*;
    logic               valid;
    logic               ready;
    logic [23:0]        out_a;
    logic [23:0]        out_b;
    logic [23:0]        out_c;
    logic [23:0]        out_d;
    logic [2:0]         channel_count;
    logic [INDEX_W-1:0] frame_number;
    logic               result_last;
    logic [INDEX_W-1:0] trim_first;
    logic [COUNT_W-1:0] trim_end;
    logic               overflow;

    modport source (output valid, out_a, out_b, out_c, out_d, channel_count, frame_number,
                           result_last, trim_first, trim_end, overflow,
                    input ready);
    modport sink   (input valid, out_a, out_b, out_c, out_d, channel_count, frame_number,
                          result_last, trim_first, trim_end, overflow,
                    output ready);
endinterface

interface irts_cfg_if;
    import irts_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/irts_route.sv
module irts_route (
    input  irts_pkg::t_cfg         i_cfg,
    input  irts_pkg::t_lanes       i_samples,
    output irts_pkg::t_lanes       o_samples,
    output irts_pkg::t_route_flags o_flags
);
    import irts_pkg::*;

    localparam t_sample MOST_NEG = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam t_sample MOST_POS = {1'b0, {(SAMPLE_W-1){1'b1}}};

    logic [2:0]    chans;
    logic [1:0]    ls;
    logic [1:0]    rs;
    logic          pass;
    logic [2:0]    ncount;
    t_sample       left;
    t_sample       right;
    t_sample       mag;
    logic          hit_start;
    logic          hit_end;

    always_comb begin
        chans = i_cfg.input_channels;
        if (chans == 3'd0) begin
            chans = 3'd1;
        end else if (chans > 3'(CH_LIMIT)) begin
            chans = 3'(CH_LIMIT);
        end

        // A mono frame has no channel 1, so it is read from channel 0.
        ls = i_cfg.left_source;
        rs = i_cfg.right_source;
        if (chans == 3'd1) begin
            if (ls == 2'd1) ls = 2'd0;
            if (rs == 2'd1) rs = 2'd0;
        end

        pass = (chans > 3'd2) && (ls == 2'd0) && (rs == 2'd1)
            && !i_cfg.left_invert && !i_cfg.right_invert;

        left  = ({1'b0, ls} < chans) ? i_samples[ls] : '0;
        right = ({1'b0, rs} < chans) ? i_samples[rs] : '0;
        if (i_cfg.left_invert) begin
            left = (left == MOST_NEG) ? MOST_POS : (~left + 1'b1);
        end
        if (i_cfg.right_invert) begin
            right = (right == MOST_NEG) ? MOST_POS : (~right + 1'b1);
        end

        if (pass) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                o_samples[i] = (3'(i) < chans) ? i_samples[i] : '0;
            end
            ncount = chans;
        end else begin
            o_samples    = '0;
            o_samples[0] = left;
            o_samples[1] = right;
            ncount       = 3'd2;
        end

        // The magnitude of the most negative sample is one above the largest threshold, so it exceeds every threshold.
        hit_start = 1'b0;
        hit_end   = 1'b0;
        for (int i = 0; i < NUM_LANES; i++) begin
            mag = o_samples[i][SAMPLE_W-1] ? (~o_samples[i] + 1'b1) : o_samples[i];
            if (3'(i) < ncount) begin
                if (mag > {1'b0, i_cfg.start_threshold}) hit_start = 1'b1;
                if (mag > {1'b0, i_cfg.end_threshold})   hit_end   = 1'b1;
            end
        end

        o_flags.hit_start     = hit_start;
        o_flags.hit_end       = hit_end;
        o_flags.channel_count = ncount;
    end

endmodule

FILE: src/impulse_route_and_trim_scan.sv
// Impulse response router and trim scanner.
// i_in carries one frame of four Q1.23 samples and a last-frame flag per transfer.
// o_out carries the routed frame, its channel count, its frame index and, on the
// frame marked last, the trim window (first frame kept, one past last frame kept).
// i_cfg writes the eight control registers by index; it is always ready and is
// meant to be used only while no frame is in flight.
// Each frame passes an input register and a result register: the result shows on
// o_out once the frame moves into the result register and leaves it when
// o_out.ready is high. One frame is taken every cycle while the receiver does not
// stall. The trim scan state advances by one frame as each frame moves from the
// input register into the result register.
// When the receiver stalls, the result register holds its frame and the input
// register takes one more frame; after that i_in.ready drops until o_out moves.
// Reset returns the registers to their defaults and clears the frame counter and
// the scan state; the scan also clears itself after each last frame.
module impulse_route_and_trim_scan (
    input  logic         i_clk,
    input  logic         i_rst_n,
    irts_in_if.sink      i_in,
    irts_out_if.source   o_out,
    irts_cfg_if.sink     i_cfg
);
    import irts_pkg::*;

    localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAP_FRAMES);
    localparam logic [INDEX_W-1:0] IDX_LAST  = INDEX_W'(CAP_FRAMES - 1);

    t_cfg               r_cfg;
    logic               r_in_valid;
    t_in_item           r_in;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [COUNT_W-1:0] r_frame_counter, n_frame_counter;
    logic               r_start_found, n_start_found;
    logic [INDEX_W-1:0] r_start_index, n_start_index;
    logic               r_end_any_found, n_end_any_found;
    logic [INDEX_W-1:0] r_end_any_index, n_end_any_index;
    logic               r_end_after_found, n_end_after_found;
    logic [INDEX_W-1:0] r_end_after_index, n_end_after_index;

    logic               advance;
    t_lanes             route_samples;
    t_route_flags       route_flags;
    logic               ovf;
    logic [INDEX_W-1:0] idx;
    logic               use_start;
    logic [INDEX_W-1:0] trim_first;
    logic [COUNT_W-1:0] trim_end;

    // Configuration port.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_INPUT_CHANNELS:  r_cfg.input_channels  <= i_cfg.data[2:0];
                REG_LEFT_SOURCE:     r_cfg.left_source     <= i_cfg.data[1:0];
                REG_RIGHT_SOURCE:    r_cfg.right_source    <= i_cfg.data[1:0];
                REG_LEFT_INVERT:     r_cfg.left_invert     <= i_cfg.data[0];
                REG_RIGHT_INVERT:    r_cfg.right_invert    <= i_cfg.data[0];
                REG_START_THRESHOLD: r_cfg.start_threshold <= i_cfg.data;
                REG_END_THRESHOLD:   r_cfg.end_threshold   <= i_cfg.data;
                REG_TRIM_ENABLE:     r_cfg.trim_enable     <= i_cfg.data[1:0];
                default: ;
            endcase
        end
    end

    // A frame moves on when the result register is empty or being emptied.
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in.samples[0] <= i_in.sample_a;
            r_in.samples[1] <= i_in.sample_b;
            r_in.samples[2] <= i_in.sample_c;
            r_in.samples[3] <= i_in.sample_d;
            r_in.frame_last <= i_in.frame_last;
        end
    end

    irts_route u_route (
        .i_cfg     (r_cfg),
        .i_samples (r_in.samples),
        .o_samples (route_samples),
        .o_flags   (route_flags)
    );

    // Trim scan.
    always_comb begin
        ovf = r_frame_counter >= CAP_COUNT;
        idx = ovf ? IDX_LAST : r_frame_counter[INDEX_W-1:0];
        n_frame_counter = ovf ? r_frame_counter : r_frame_counter + 1'b1;

        n_start_found     = r_start_found;
        n_start_index     = r_start_index;
        n_end_any_found   = r_end_any_found;
        n_end_any_index   = r_end_any_index;
        n_end_after_found = r_end_after_found;
        n_end_after_index = r_end_after_index;

        if (!r_start_found && route_flags.hit_start) begin
            n_start_found = 1'b1;
            n_start_index = idx;
        end
        // The end after the start counts a frame that is itself the start frame.
        if (route_flags.hit_end) begin
            n_end_any_found = 1'b1;
            n_end_any_index = idx;
            if (n_start_found) begin
                n_end_after_found = 1'b1;
                n_end_after_index = idx;
            end
        end

        use_start  = r_cfg.trim_enable[0] && n_start_found;
        trim_first = use_start ? n_start_index : '0;
        trim_end   = {1'b0, idx} + 1'b1;
        if (r_cfg.trim_enable[1]) begin
            if (use_start) begin
                if (n_end_after_found) trim_end = {1'b0, n_end_after_index} + 1'b1;
            end else begin
                if (n_end_any_found) trim_end = {1'b0, n_end_any_index} + 1'b1;
            end
        end

        if (r_in.frame_last) begin
            n_frame_counter   = '0;
            n_start_found     = 1'b0;
            n_start_index     = '0;
            n_end_any_found   = 1'b0;
            n_end_any_index   = '0;
            n_end_after_found = 1'b0;
            n_end_after_index = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_counter   <= '0;
            r_start_found     <= 1'b0;
            r_start_index     <= '0;
            r_end_any_found   <= 1'b0;
            r_end_any_index   <= '0;
            r_end_after_found <= 1'b0;
            r_end_after_index <= '0;
        end else if (advance) begin
            r_frame_counter   <= n_frame_counter;
            r_start_found     <= n_start_found;
            r_start_index     <= n_start_index;
            r_end_any_found   <= n_end_any_found;
            r_end_any_index   <= n_end_any_index;
            r_end_after_found <= n_end_after_found;
            r_end_after_index <= n_end_after_index;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out.samples       <= route_samples;
            r_out.channel_count <= route_flags.channel_count;
            r_out.frame_number  <= idx;
            r_out.result_last   <= r_in.frame_last;
            r_out.trim_first    <= r_in.frame_last ? trim_first : '0;
            r_out.trim_end      <= r_in.frame_last ? trim_end : '0;
            r_out.overflow      <= ovf;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.out_a         = r_out.samples[0];
    assign o_out.out_b         = r_out.samples[1];
    assign o_out.out_c         = r_out.samples[2];
    assign o_out.out_d         = r_out.samples[3];
    assign o_out.channel_count = r_out.channel_count;
    assign o_out.frame_number  = r_out.frame_number;
    assign o_out.result_last   = r_out.result_last;
    assign o_out.trim_first    = r_out.trim_first;
    assign o_out.trim_end      = r_out.trim_end;
    assign o_out.overflow      = r_out.overflow;

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in.frame_last |=> r_frame_counter == '0 && !r_start_found
            && !r_end_any_found && !r_end_after_found)
        else $error("scan state not cleared after last frame");

    a_counter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame_counter <= CAP_COUNT)
        else $error("frame counter beyond capacity");

    a_after_needs_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_end_after_found |-> r_start_found)
        else $error("end after start found without a start frame");

    a_bounds_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.result_last |-> r_out.trim_first == '0 && r_out.trim_end == '0)
        else $error("trim bounds on a frame that is not last");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.channel_count >= 3'd2 && r_out.channel_count <= 3'(CH_LIMIT))
        else $error("channel count out of range");

endmodule
